FILE: rtl/threefry_random_bits_gen_assert.svh
// Assertion macros for the Threefry random bits generator.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef THREEFRY_RANDOM_BITS_GEN_ASSERT_SVH
`define THREEFRY_RANDOM_BITS_GEN_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define TRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/trf_pkg.sv
// Shared constants, the word type passed along the round chain, and the
// Threefry-2x32 helper functions. No dependencies.
package trf_pkg;

   localparam int MAX_WORDS_PER_KEY = 16384;
   localparam int MAX_BYTES_PER_KEY = 4 * MAX_WORDS_PER_KEY;

   localparam int BPK_W    = 17;
   localparam int WORDS_W  = $clog2(MAX_WORDS_PER_KEY + 1);
   localparam int INDEX_W  = 13;
   localparam int OFFSET_W = 16;
   localparam int COUNT_W  = 3;

   localparam int NUM_ROUNDS       = 20;
   localparam int ROUNDS_PER_GROUP = 4;
   localparam int ROUND_W          = $clog2(NUM_ROUNDS);
   localparam int GROUP_W          = $clog2(NUM_ROUNDS / ROUNDS_PER_GROUP);

   localparam logic [31:0]    TF_PARITY     = 32'h1BD1_1BDA;
   localparam logic [COUNT_W-1:0] FULL_WORD = 3'd4;

   localparam logic [4:0] ROT_TABLE [8] = '{
      5'd13, 5'd15, 5'd26, 5'd6, 5'd17, 5'd29, 5'd16, 5'd24
   };

   // Key schedule word selectors.
   localparam logic [1:0] KS_LO     = 2'd0;
   localparam logic [1:0] KS_HI     = 2'd1;
   localparam logic [1:0] KS_PARITY = 2'd2;

   typedef struct packed {
      logic [31:0]         x0;
      logic [31:0]         x1;
      logic [31:0]         k0;
      logic [31:0]         k1;
      logic [OFFSET_W-1:0] offset_a;
      logic [COUNT_W-1:0]  bytes_a;
      logic                zero_a;
      logic [OFFSET_W-1:0] offset_b;
      logic [COUNT_W-1:0]  bytes_b;
      logic                zero_b;
   } trf_item_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] amt);
      logic [5:0] amt6;
      amt6 = {1'b0, amt};
      return (v << amt6) | (v >> (6'd32 - amt6));
   endfunction

   function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] round_idx);
      return ROT_TABLE[round_idx[2:0]];
   endfunction

   // Key schedule word added to x0 after group g; x1 takes the following one.
   function automatic logic [1:0] ks_sel_x0(input logic [GROUP_W-1:0] group_idx);
      logic [1:0] sel;
      case (group_idx)
         3'd0:    sel = KS_HI;
         3'd1:    sel = KS_PARITY;
         3'd2:    sel = KS_LO;
         3'd3:    sel = KS_HI;
         3'd4:    sel = KS_PARITY;
         default: sel = KS_LO;
      endcase
      return sel;
   endfunction

   function automatic logic [1:0] ks_next(input logic [1:0] sel);
      logic [1:0] nxt;
      case (sel)
         KS_LO:   nxt = KS_HI;
         KS_HI:   nxt = KS_PARITY;
         default: nxt = KS_LO;
      endcase
      return nxt;
   endfunction

   function automatic logic [31:0] ks_word(input logic [1:0] sel,
                                           input logic [31:0] k0,
                                           input logic [31:0] k1);
      logic [31:0] w;
      case (sel)
         KS_LO:   w = k0;
         KS_HI:   w = k1;
         default: w = k0 ^ k1 ^ TF_PARITY;
      endcase
      return w;
   endfunction

   function automatic logic [COUNT_W-1:0] word_bytes(input logic [WORDS_W-1:0] idx,
                                                     input logic [WORDS_W-1:0] words,
                                                     input logic [1:0] tail);
      logic [COUNT_W-1:0] n;
      if (idx >= words) begin
         n = '0;
      end else if ((idx == words - WORDS_W'(1)) && (tail != 2'd0)) begin
         n = COUNT_W'(tail);
      end else begin
         n = FULL_WORD;
      end
      return n;
   endfunction

endpackage

FILE: rtl/trf_prep.sv
// Front stage: holds the byte count per key, derives the word layout, forms
// the counter pair and applies the first key injection. Depends on trf_pkg.
module trf_prep
   import trf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [BPK_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_key_lo,
   input  logic [31:0]         req_key_hi,
   input  logic [INDEX_W-1:0]  req_pair_index,
   output logic                down_valid,
   output trf_item_type        down_item,
   input  logic                down_ready
);

   logic [BPK_W-1:0]   bpk_ff, bpk_in;
   logic               valid_ff, valid_in;
   trf_item_type       item_ff, item_in;
   logic               up_ready;

   logic [BPK_W-1:0]   bpk_sat;
   logic [BPK_W:0]     bpk_round;
   logic [WORDS_W-1:0] words;
   logic [WORDS_W:0]   words_round;
   logic [WORDS_W-1:0] half;
   logic [WORDS_W-1:0] y;
   logic [WORDS_W:0]   idx_b_wide;
   logic [WORDS_W-1:0] idx_b;
   logic               in_range;
   logic               drop;
   logic [31:0]        c1;
   logic [OFFSET_W+1:0] offset_b_wide;

   assign bpk_in = csr_write_en ? csr_write_data : bpk_ff;

   always_comb begin
      bpk_sat = (bpk_ff > BPK_W'(MAX_BYTES_PER_KEY)) ? BPK_W'(MAX_BYTES_PER_KEY) : bpk_ff;
      bpk_round   = {1'b0, bpk_sat} + (BPK_W+1)'(3);
      words       = bpk_round[WORDS_W+1:2];
      words_round = {1'b0, words} + (WORDS_W+1)'(1);
      half        = words_round[WORDS_W:1];
      y           = WORDS_W'(req_pair_index);
      in_range    = y < half;
      drop        = words[0] && (y == half - WORDS_W'(1));
      idx_b_wide  = {1'b0, y} + {1'b0, half};
      idx_b       = idx_b_wide[WORDS_W-1:0];
      c1          = drop ? 32'd0 : 32'(idx_b);
      offset_b_wide = {idx_b_wide, 2'b00};

      item_in.x0 = 32'(req_pair_index) + req_key_lo;
      item_in.x1 = c1 + req_key_hi;
      item_in.k0 = req_key_lo;
      item_in.k1 = req_key_hi;
      item_in.zero_a   = !in_range;
      item_in.zero_b   = !in_range || drop;
      item_in.offset_a = in_range ? OFFSET_W'({req_pair_index, 2'b00}) : '0;
      item_in.bytes_a  = in_range ? word_bytes(y, words, bpk_sat[1:0]) : '0;
      item_in.offset_b = item_in.zero_b ? '0 : offset_b_wide[OFFSET_W-1:0];
      item_in.bytes_b  = item_in.zero_b ? '0 : word_bytes(idx_b, words, bpk_sat[1:0]);
   end

   assign up_ready  = !valid_ff || down_ready;
   assign req_stall = !up_ready;
   assign valid_in  = up_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpk_ff   <= BPK_W'(4);
         valid_ff <= 1'b0;
      end else begin
         bpk_ff   <= bpk_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && req_valid) begin
         item_ff <= item_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_item  = item_ff;

endmodule

FILE: rtl/trf_round_cell.sv
// One Threefry-2x32 round with the key injection that closes every group
// of four rounds; one link of the round chain. Depends on trf_pkg.
module trf_round_cell
   import trf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ROUND_W-1:0] round_idx,
   input  logic               up_valid,
   input  trf_item_type       up_item,
   output logic               up_ready,
   output logic               down_valid,
   output trf_item_type       down_item,
   input  logic               down_ready
);

   logic         valid_ff, valid_in;
   trf_item_type item_ff, item_in;

   logic [31:0]        mix0;
   logic [31:0]        mix1;
   logic               inject;
   logic [GROUP_W-1:0] group_idx;
   logic [1:0]         sel0;

   always_comb begin
      mix0      = up_item.x0 + up_item.x1;
      mix1      = rotl32(up_item.x1, rot_amount(round_idx)) ^ mix0;
      inject    = (round_idx[1:0] == 2'b11);
      group_idx = GROUP_W'(round_idx >> 2);
      sel0      = ks_sel_x0(group_idx);
      item_in   = up_item;
      if (inject) begin
         item_in.x0 = mix0 + ks_word(sel0, up_item.k0, up_item.k1);
         item_in.x1 = mix1 + ks_word(ks_next(sel0), up_item.k0, up_item.k1)
                      + 32'(group_idx) + 32'd1;
      end else begin
         item_in.x0 = mix0;
         item_in.x1 = mix1;
      end
   end

   // A cell takes a new word when empty or when its own word moves on.
   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_item  = item_ff;

endmodule

FILE: rtl/threefry_random_bits_gen.sv
// Top level of the Threefry-2x32-20 counter-mode random bits generator:
// front stage followed by a chain of twenty round cells. Depends on trf_pkg,
// trf_prep, trf_round_cell and threefry_random_bits_gen_assert.svh.
//
//   Port group | Direction | Content
//   req_*      | in        | key_lo, key_hi, pair_index (valid / stall)
//   rsp_*      | out       | word_a/b, offset_a/b, bytes_a/b (valid / stall)
//   csr_*      | in        | byte count per key write, no read-back
//
// One word is taken per cycle while req_stall is low. Each word passes the
// front stage and then one round cell per round, the four-round key
// injection sharing the cell of the last round of its group.
// Reset empties every stage and sets the byte count per key to 4.
// A stall on rsp_stall holds the last cell; cells further back keep filling
// until they meet an occupied neighbour, so empty slots are squeezed out.
`include "threefry_random_bits_gen_assert.svh"

module threefry_random_bits_gen
   import trf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [BPK_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_key_lo,
   input  logic [31:0]         req_key_hi,
   input  logic [INDEX_W-1:0]  req_pair_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_word_a,
   output logic [OFFSET_W-1:0] rsp_offset_a,
   output logic [COUNT_W-1:0]  rsp_bytes_a,
   output logic [31:0]         rsp_word_b,
   output logic [OFFSET_W-1:0] rsp_offset_b,
   output logic [COUNT_W-1:0]  rsp_bytes_b
);

   logic         chain_valid [NUM_ROUNDS+1];
   logic         chain_ready [NUM_ROUNDS+1];
   trf_item_type chain_item  [NUM_ROUNDS+1];
   trf_item_type last_item;

   trf_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_lo     (req_key_lo),
      .req_key_hi     (req_key_hi),
      .req_pair_index (req_pair_index),
      .down_valid     (chain_valid[0]),
      .down_item      (chain_item[0]),
      .down_ready     (chain_ready[0])
   );

   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
      trf_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .round_idx  (ROUND_W'(i)),
         .up_valid   (chain_valid[i]),
         .up_item    (chain_item[i]),
         .up_ready   (chain_ready[i]),
         .down_valid (chain_valid[i+1]),
         .down_item  (chain_item[i+1]),
         .down_ready (chain_ready[i+1])
      );
   end

   assign chain_ready[NUM_ROUNDS] = !rsp_stall;
   assign last_item = chain_item[NUM_ROUNDS];

   assign rsp_valid    = chain_valid[NUM_ROUNDS];
   assign rsp_word_a   = last_item.zero_a ? 32'd0 : last_item.x0;
   assign rsp_offset_a = last_item.offset_a;
   assign rsp_bytes_a  = last_item.bytes_a;
   assign rsp_word_b   = last_item.zero_b ? 32'd0 : last_item.x1;
   assign rsp_offset_b = last_item.offset_b;
   assign rsp_bytes_b  = last_item.bytes_b;

   // An empty first word means the pair lay outside the key's output.
   `TRF_ASSERT_NOW(a_empty_pair_zero, rsp_valid && (rsp_bytes_a == '0),
      (rsp_word_a == '0) && (rsp_offset_a == '0) && (rsp_bytes_b == '0),
      "out of range pair carries data")
   `TRF_ASSERT_NOW(a_dropped_b_zero, rsp_valid && (rsp_bytes_b == '0),
      (rsp_word_b == '0) && (rsp_offset_b == '0), "dropped second word carries data")
   // With both words present the first can never be the tail word.
   `TRF_ASSERT_NOW(a_pair_layout, rsp_valid && (rsp_bytes_b != '0),
      (rsp_bytes_a == FULL_WORD) && (rsp_offset_b > rsp_offset_a),
      "word pair layout inconsistent")
   `TRF_ASSERT_NEXT(a_accept_fills_front, req_valid && !req_stall, chain_valid[0],
      "accepted word lost at the front stage")

endmodule
